// File: rtl/core/pcuc_pkg.sv
// package for the pair code uniqueness checker: request/response structs,
// controller states, command/status structs and sizing constants
`timescale 1ns / 1ps

package pcuc_pkg;

   localparam int TablePatternsDef = 64;
   localparam int SchemeMaxDef     = 32;
   localparam int CodeCountDef     = 256;
   localparam int NumPatternsReset = 64;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_TRY   = 2'd1,
      REQ_ADD   = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_REJECTED = 2'd1,
      ST_FULL     = 2'd2
   } rsp_status_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] code;
      logic [5:0] candidate;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       fits;
      logic [5:0] member_total;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_CHK,
      S_SELF_RD,
      S_SELF_CHK,
      S_WIPE,
      S_RESP
   } ctl_state_type;

   // address selector for the table read
   typedef enum logic [1:0] {
      A_PN,
      A_NP,
      A_NN
   } addr_sel_type;

   typedef struct packed {
      logic         start;      // capture request
      logic         do_load;
      logic         do_clear;   // clear members, start map wipe
      logic         member_rd;  // read member list at index
      addr_sel_type tbl_sel;
      logic         latch_c1;
      logic         pair_check; // evaluate pair, mark trial or used
      logic         self_check;
      logic         append;
      logic         wipe_step;
      logic         idx_inc;
      logic         rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       present;
      logic       full;
      logic       idx_last;  // index reached member count
      logic       fail;      // a check has failed
      logic       wipe_last;
      logic       rsp_busy;
   } ctl_stat_type;

endpackage

// File: rtl/core/pcuc_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pcuc_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;

endmodule

// File: rtl/core/pcuc_ctrl.sv
// controller state machine for the pair code uniqueness checker
// uses pcuc_pkg
`timescale 1ns / 1ps

module pcuc_ctrl
   import pcuc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;
   logic          is_add_ff, is_add_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         is_add_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         is_add_ff <= is_add_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      is_add_in = is_add_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !stat.rsp_busy) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // captured request is dispatched here
            unique case (req_kind_type'(stat.kind))
               REQ_LOAD:  state_in = S_IDLE;
               REQ_CLEAR: state_in = S_WIPE;
               REQ_TRY: begin
                  is_add_in = 1'b0;
                  state_in  = stat.present ? S_WIPE : S_RD1;
               end
               REQ_ADD: begin
                  is_add_in = 1'b1;
                  state_in  = stat.full ? S_IDLE : S_RD1;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RD1: begin
            if (stat.idx_last) begin
               state_in = S_SELF_RD;
            end else begin
               state_in = S_RD2;
            end
         end
         S_RD2:      state_in = S_CHK;
         S_CHK: begin
            if (stat.fail) begin
               state_in = S_WIPE;
            end else begin
               state_in = S_RD1;
            end
         end
         S_SELF_RD:  state_in = S_SELF_CHK;
         S_SELF_CHK: state_in = is_add_ff ? S_IDLE : S_WIPE;
         S_WIPE: begin
            if (stat.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.tbl_sel = A_PN;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = stat.rsp_busy;
            cmd.start = req_valid && !stat.rsp_busy;
         end
         S_RESP: begin
            unique case (req_kind_type'(stat.kind))
               REQ_LOAD: begin
                  cmd.do_load  = 1'b1;
                  cmd.rsp_load = 1'b1;
               end
               REQ_CLEAR: cmd.do_clear = 1'b1;
               REQ_TRY:   cmd.member_rd = 1'b1;
               REQ_ADD: begin
                  cmd.rsp_load = stat.full;
                  cmd.append   = !stat.full;
                  cmd.member_rd = 1'b1;
               end
               default: ;
            endcase
         end
         S_RD1: begin
            cmd.tbl_sel = A_PN;
         end
         S_RD2: begin
            cmd.tbl_sel  = A_NP;
            cmd.latch_c1 = 1'b1;
         end
         S_CHK: begin
            cmd.pair_check = 1'b1;
            cmd.idx_inc    = 1'b1;
            cmd.member_rd  = 1'b1;
         end
         S_SELF_RD: begin
            cmd.tbl_sel = A_NN;
         end
         S_SELF_CHK: begin
            cmd.self_check = 1'b1;
            cmd.rsp_load   = is_add_ff;
         end
         S_WIPE: begin
            cmd.wipe_step = 1'b1;
            cmd.rsp_load  = stat.wipe_last;
         end
         default: ;
      endcase
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("request taken while busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == S_RESP)) else $error("start did not dispatch");
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      cmd.do_load |=> (state_ff == S_IDLE)) else $error("load took more than one step");

endmodule

// File: rtl/core/pcuc_dp.sv
// datapath: pair code table ram, member list, code maps and response register
// uses pcuc_pkg and pcuc_ram
`timescale 1ns / 1ps

module pcuc_dp
   import pcuc_pkg::*;
#(
   parameter int TablePatterns = TablePatternsDef,
   parameter int SchemeMax     = SchemeMaxDef,
   parameter int CodeCount     = CodeCountDef
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [6:0]      csr_wr_data,
   input  req_payload_type req_data,
   input  ctl_cmd_type     cmd,
   output ctl_stat_type    stat,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int TableDepth = TablePatterns * TablePatterns;
   localparam int TaW = $clog2(TableDepth);
   localparam int CiW = $clog2(CodeCount);
   localparam int MiW = (SchemeMax > 1) ? $clog2(SchemeMax) : 1;
   localparam int McW = $clog2(SchemeMax + 1);

   logic [6:0]      npat_ff;
   req_payload_type req_ff;
   logic [McW-1:0]  count_ff, count_in;
   logic [McW-1:0]  idx_ff;
   logic [McW-1:0]  idx_rd;
   logic [5:0]      mlist_ff [SchemeMax];
   logic [63:0]     present_ff;
   logic [CodeCount-1:0] used_ff, trial_ff;
   logic [5:0]      p_ff;
   logic [7:0]      c1_ff;
   logic            fail_ff;
   logic            rv_ff;
   rsp_payload_type rsp_ff;

   // table address: (r * m + c) mod depth
   logic [5:0]  ar, ac;
   logic [13:0] prod;
   logic [TaW-1:0] taddr;
   logic        twr;
   logic [7:0]  tdata;

   always_comb begin
      ar = req_ff.row;
      ac = req_ff.col;
      if (!cmd.do_load) begin
         unique case (cmd.tbl_sel)
            A_PN: begin ar = p_ff;              ac = req_ff.candidate; end
            A_NP: begin ar = req_ff.candidate;  ac = p_ff;             end
            default: begin ar = req_ff.candidate; ac = req_ff.candidate; end
         endcase
      end
   end
   assign prod  = 14'(ar) * 14'(npat_ff);
   assign taddr = TaW'(prod + 14'(ac));
   assign twr   = cmd.do_load;

   pcuc_ram #(.Width(8), .Depth(TableDepth)) u_table (
      .clock   (clock),
      .wr_en   (twr),
      .addr    (taddr),
      .wr_data (req_ff.code),
      .rd_data (tdata)
   );

   logic [CiW-1:0] c1i, c2i;
   logic pair_bad, self_bad;
   logic [CodeCount-1:0] pair_mask, self_mask;
   assign c1i = CiW'(c1_ff);
   assign c2i = CiW'(tdata);
   assign pair_bad = used_ff[c1i] || used_ff[c2i] || (c1i == c2i) ||
                     trial_ff[c1i] || trial_ff[c2i];
   assign self_bad = used_ff[c2i] || trial_ff[c2i];
   assign self_mask = CodeCount'(1) << c2i;
   assign pair_mask = (CodeCount'(1) << c1i) | self_mask;

   logic is_add;
   assign is_add = (req_ff.req_type == REQ_ADD);
   assign count_in = count_ff + McW'(1);

   // the walk prefetches the next member while the index steps
   assign idx_rd = cmd.idx_inc ? idx_ff + McW'(1) : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) req_ff <= req_data;
      if (cmd.latch_c1) c1_ff <= tdata;
      if (cmd.append) mlist_ff[MiW'(count_ff)] <= req_ff.candidate;
      if (cmd.append) p_ff <= (count_ff == '0) ? req_ff.candidate : mlist_ff[0];
      else if (cmd.member_rd) p_ff <= mlist_ff[MiW'(idx_rd)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         npat_ff    <= 7'(NumPatternsReset);
         count_ff   <= '0;
         idx_ff     <= '0;
         present_ff <= '0;
         used_ff    <= '0;
         trial_ff   <= '0;
         fail_ff    <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) npat_ff <= csr_wr_data;
         if (cmd.start) begin
            idx_ff  <= '0;
            fail_ff <= 1'b0;
         end
         if (cmd.append) begin
            count_ff <= count_in;
            present_ff[req_ff.candidate] <= 1'b1;
         end
         if (cmd.do_clear) begin
            count_ff   <= '0;
            present_ff <= '0;
            used_ff    <= '0;
         end
         if (cmd.pair_check) begin
            idx_ff <= idx_ff + McW'(1);
            if (is_add) begin
               used_ff <= used_ff | pair_mask;
            end else if (pair_bad) begin
               fail_ff <= 1'b1;
            end else begin
               trial_ff <= trial_ff | pair_mask;
            end
         end
         if (cmd.self_check) begin
            if (is_add) used_ff <= used_ff | self_mask;
            else if (self_bad) fail_ff <= 1'b1;
         end
         if (cmd.wipe_step) begin
            // drop the trial marks of this request
            trial_ff <= '0;
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (cmd.rsp_load) rv_ff <= 1'b1;
      end
   end

   // response assembly
   logic [1:0] st;
   logic       ft;
   always_comb begin
      st = ST_DONE;
      ft = 1'b0;
      priority if (is_add && stat.full && !cmd.self_check) st = ST_FULL;
      else if (req_ff.req_type == REQ_TRY) begin
         if (fail_ff || present_ff[req_ff.candidate]) st = ST_REJECTED;
         else ft = 1'b1;
      end
      else st = ST_DONE;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status       <= st;
         rsp_ff.fits         <= ft;
         rsp_ff.member_total <= 6'(count_ff);
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   assign stat.kind      = req_ff.req_type;
   assign stat.present   = present_ff[req_ff.candidate];
   assign stat.full      = (count_ff >= McW'(SchemeMax));
   assign stat.idx_last  = (idx_ff >= count_ff);
   assign stat.fail      = fail_ff || (cmd.pair_check && !is_add && pair_bad);
   assign stat.wipe_last = 1'b1;
   assign stat.rsp_busy  = rv_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= McW'(SchemeMax)) else $error("member count overflow");
   a_trial_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (trial_ff == '0)) else $error("trial map not cleared");
   a_append_present: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> present_ff[$past(req_ff.candidate)]) else $error("present bit missed");

endmodule

// File: rtl/core/pairwise_code_uniqueness_checker_core.sv
// Pair code uniqueness checker. One request at a time: a load or an add on a full
// scheme is answered from the dispatch state S_RESP, a clear or a try of a candidate
// already present after S_WIPE, an add after the member walk and the self check, and
// a try after the member walk, the self check (unless a pair check fails) and S_WIPE.
// The member walk steps through S_RD1, S_RD2 and S_CHK for each member because the
// single table ram read port serves both directional codes. The response register
// holds a result until taken; the next request can be taken once the response has left.
// uses pcuc_pkg, pcuc_ctrl, pcuc_dp
`timescale 1ns / 1ps

module pairwise_code_uniqueness_checker_core
   import pcuc_pkg::*;
#(
   parameter int TablePatterns = TablePatternsDef,
   parameter int SchemeMax     = SchemeMaxDef,
   parameter int CodeCount     = CodeCountDef
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [6:0]      csr_wr_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   pcuc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcuc_dp #(
      .TablePatterns (TablePatterns),
      .SchemeMax     (SchemeMax),
      .CodeCount     (CodeCount)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: tb/tb_pairwise_code_uniqueness_checker_core.sv
// testbench for pairwise_code_uniqueness_checker_core: a directed table, an add run, then random
// request phases at several row lengths, checked by an in-bench predictor or typed-in responses
// depends on pcuc_pkg and the core rtl
`timescale 1ns / 1ps

module tb_pairwise_code_uniqueness_checker_core;
   import pcuc_pkg::*;

   localparam int TableDepth = TablePatternsDef * TablePatternsDef;
   localparam int CycleLimit = 3000000;
   localparam int SettleCycles = 100;
   localparam int KnownCount = 6;

   typedef struct {
      req_payload_type req;
      bit              typed;
      rsp_payload_type rsp;
   } directed_row_type;

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic [6:0]      csr_wr_data;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   // side info travelling with the request: a typed-in expected response
   bit              req_typed;
   rsp_payload_type req_typed_rsp;

   // predictor state
   logic [7:0]  model_codes [TableDepth];
   bit [255:0]  used_codes = '0;
   logic [5:0]  members [SchemeMaxDef];
   bit [63:0]   present = '0;
   int unsigned member_cnt = 0;
   logic [6:0]  row_len = 7'(NumPatternsReset);

   rsp_payload_type expected_rsp_q[$];
   directed_row_type dir_rows[$];
   bit          failed = 1'b0;
   int unsigned cycle_cnt = 0;
   int unsigned stall_left = 0;

   pairwise_code_uniqueness_checker_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned table_addr(int unsigned r, int unsigned c);
      return (r * row_len + c) % TableDepth;
   endfunction

   function automatic int unsigned code_at(int unsigned r, int unsigned c);
      return model_codes[table_addr(r, c)];
   endfunction

   function automatic bit candidate_fits(int unsigned n);
      bit [255:0]  seen;
      int unsigned c1;
      int unsigned c2;
      int unsigned s;
      seen = '0;
      if (present[n]) return 1'b0;
      for (int i = 0; i < member_cnt && i < SchemeMaxDef; i++) begin
         c1 = code_at(members[i], n);
         c2 = code_at(n, members[i]);
         if (used_codes[c1] || used_codes[c2] || c1 == c2 || seen[c1] || seen[c2])
            return 1'b0;
         seen[c1] = 1'b1;
         seen[c2] = 1'b1;
      end
      s = code_at(n, n);
      return !(used_codes[s] || seen[s]);
   endfunction

   function automatic rsp_payload_type predict_response(req_payload_type q);
      rsp_payload_type r;
      r.status = ST_DONE;
      r.fits   = 1'b0;
      case (q.req_type)
         REQ_LOAD: begin
            model_codes[table_addr(q.row, q.col)] = q.code;
         end
         REQ_TRY: begin
            if (candidate_fits(q.candidate)) r.fits = 1'b1;
            else r.status = ST_REJECTED;
         end
         REQ_ADD: begin
            if (member_cnt >= SchemeMaxDef) begin
               r.status = ST_FULL;
            end else begin
               members[member_cnt] = q.candidate;
               member_cnt++;
               present[q.candidate] = 1'b1;
               for (int i = 0; i < member_cnt; i++) begin
                  used_codes[code_at(members[i], q.candidate)] = 1'b1;
                  used_codes[code_at(q.candidate, members[i])] = 1'b1;
               end
               used_codes[code_at(q.candidate, q.candidate)] = 1'b1;
            end
         end
         default: begin
            used_codes = '0;
            present    = '0;
            member_cnt = 0;
         end
      endcase
      r.member_total = member_cnt[5:0];
      return r;
   endfunction

   // request accept and response check, on values sampled before the edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_response(req_data);
            if (req_typed) want = req_typed_rsp;
            expected_rsp_q.insert(expected_rsp_q.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, actual %p", $time, rsp_data);
               failed = 1'b1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.fits !== want.fits ||
                   rsp_data.member_total !== want.member_total) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // response side back-pressure: mostly free, short bursts, a few long ones
   always @(posedge clock) begin
      int unsigned pick;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= (pick < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // candidates come from a small known set whose pair entries are always loaded
   function automatic logic [5:0] known_index(int unsigned k);
      case (k)
         0:       return 6'd0;
         1:       return 6'd1;
         2:       return 6'd5;
         3:       return 6'd7;
         4:       return 6'd62;
         default: return 6'd63;
      endcase
   endfunction

   function automatic logic [5:0] random_known();
      return known_index($urandom_range(0, KnownCount - 1));
   endfunction

   function automatic int unsigned gap_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic void add_row(req_payload_type q, bit typed, rsp_payload_type e);
      directed_row_type d;
      d.req   = q;
      d.typed = typed;
      d.rsp   = e;
      dir_rows.insert(dir_rows.size(), d);
   endfunction

   task automatic send(req_payload_type q, bit typed, rsp_payload_type e, bit allow_gap);
      int unsigned g;
      req_valid     <= 1'b1;
      req_data      <= q;
      req_typed     <= typed;
      req_typed_rsp <= e;
      do @(posedge clock); while (req_stall);
      g = allow_gap ? gap_len() : 0;
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_row_len(logic [6:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      row_len     = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_payload_type random_request(int unsigned clear_pct);
      req_payload_type q;
      int unsigned     pick;
      q = req_payload_type'($bits(req_payload_type)'($urandom));
      q.candidate = random_known();
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) q.req_type = REQ_CLEAR;
      else if (pick < 22) q.req_type = REQ_LOAD;
      else if (pick < 60) q.req_type = REQ_TRY;
      else q.req_type = REQ_ADD;
      return q;
   endfunction

   function automatic rsp_payload_type rsp_of(rsp_status_type s, logic f, logic [5:0] t);
      rsp_payload_type r;
      r.status       = s;
      r.fits         = f;
      r.member_total = t;
      return r;
   endfunction

   function automatic req_payload_type req_of(req_kind_type k, logic [5:0] r, logic [5:0] c,
                                              logic [7:0] v, logic [5:0] n);
      req_payload_type q;
      q.req_type  = k;
      q.row       = r;
      q.col       = c;
      q.code      = v;
      q.candidate = n;
      return q;
   endfunction

   // load every pair entry among the known set at the current row length
   task automatic fill_pairs();
      for (int unsigned i = 0; i < KnownCount; i++)
         for (int unsigned j = 0; j < KnownCount; j++)
            send(req_of(REQ_LOAD, known_index(i), known_index(j),
                        8'($urandom_range(0, 63)), 6'd0), 1'b0, '0, 1'b0);
   endtask

   initial begin
      req_payload_type  q;
      logic [6:0]       phase_len [5];
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      req_typed   = 1'b0;
      req_typed_rsp = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // clear straight after reset, then fill the known pair entries at the reset row length
      send(req_of(REQ_CLEAR, 0, 0, 0, 0), 1'b1, rsp_of(ST_DONE, 0, 0), 1'b0);
      fill_pairs();

      add_row(req_of(REQ_LOAD, 63, 63, 8'hff, 0), 1'b1, rsp_of(ST_DONE, 0, 0));
      add_row(req_of(REQ_LOAD, 0, 0, 8'h00, 63), 1'b1, rsp_of(ST_DONE, 0, 0));
      add_row(req_of(REQ_LOAD, 0, 63, 8'h01, 0), 1'b1, rsp_of(ST_DONE, 0, 0));
      add_row(req_of(REQ_LOAD, 63, 0, 8'h01, 0), 1'b1, rsp_of(ST_DONE, 0, 0));
      // empty scheme, unused self code: fits
      add_row(req_of(REQ_TRY, 0, 0, 0, 0), 1'b1, rsp_of(ST_DONE, 1, 0));
      add_row(req_of(REQ_ADD, 0, 0, 0, 0), 1'b1, rsp_of(ST_DONE, 0, 1));
      // already a member
      add_row(req_of(REQ_TRY, 0, 0, 0, 0), 1'b1, rsp_of(ST_REJECTED, 0, 1));
      // equal directional codes against member 0
      add_row(req_of(REQ_TRY, 0, 0, 0, 63), 1'b1, rsp_of(ST_REJECTED, 0, 1));
      add_row(req_of(REQ_LOAD, 63, 0, 8'h02, 0), 1'b0, '0);
      add_row(req_of(REQ_TRY, 63, 63, 8'hff, 63), 1'b0, '0);
      add_row(req_of(REQ_ADD, 63, 63, 8'hff, 63), 1'b1, rsp_of(ST_DONE, 0, 2));
      add_row(req_of(REQ_TRY, 0, 0, 0, 5), 1'b0, '0);
      // add without membership test
      add_row(req_of(REQ_ADD, 0, 0, 0, 63), 1'b1, rsp_of(ST_DONE, 0, 3));
      add_row(req_of(REQ_TRY, 1, 2, 3, 7), 1'b0, '0);
      add_row(req_of(REQ_CLEAR, 63, 63, 8'hff, 63), 1'b1, rsp_of(ST_DONE, 0, 0));
      add_row(req_of(REQ_TRY, 0, 0, 0, 63), 1'b0, '0);
      foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, 1'b1);

      // a long add run until the scheme is full
      for (int i = 0; i < SchemeMaxDef; i++)
         send(req_of(REQ_ADD, 0, 0, 0, random_known()), 1'b0, '0, 1'b1);
      send(req_of(REQ_ADD, 0, 0, 0, 1), 1'b1, rsp_of(ST_FULL, 0, 6'(SchemeMaxDef)), 1'b1);
      send(req_of(REQ_TRY, 0, 0, 0, random_known()), 1'b0, '0, 1'b1);

      phase_len = '{7'd64, 7'd1, 7'd127, 7'd0, 7'($urandom_range(2, 63))};
      foreach (phase_len[p]) begin
         write_row_len(phase_len[p]);
         fill_pairs();
         for (int i = 0; i < 30; i++) begin
            q = random_request(8);
            send(q, 1'b0, '0, 1'b1);
         end
      end

      drain();
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
